@@ src/divide_128_bit_assert.svh @@
// Assertion macros shared by the divider RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef DIVIDE_128_BIT_ASSERT_SVH
`define DIVIDE_128_BIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DIV128_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DIV128_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/div128_pkg.sv @@
// Shared types and constants for the 128-bit divider.
// No dependencies; used by the core and the top level.
package div128_pkg;

  localparam int unsigned DataWidth = 128;
  localparam int unsigned HalfWidth = 64;
  localparam int unsigned SignBit   = 127;
  localparam int unsigned CountWidth = $clog2(DataWidth);

  typedef logic [DataWidth-1:0]  word_t;
  typedef logic [HalfWidth-1:0]  half_t;
  typedef logic [CountWidth-1:0] count_t;

  // Mode codes carried in the action field.
  localparam logic ACT_UNSIGNED = 1'b0;
  localparam logic ACT_SIGNED   = 1'b1;

  typedef struct packed {
    logic  action;
    word_t dividend;
    word_t divisor;
  } operand_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } result_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_NEG_N = 6'b000010,
    ST_NEG_D = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_NEG_Q = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage

@@ src/div128_in_if.sv @@
// Operand channel of the 128-bit divider: valid/ready plus operand fields.
// Depends on nothing beyond the language itself.
interface div128_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [63:0] dividend_high;
  logic [63:0] dividend_low;
  logic [63:0] divisor_high;
  logic [63:0] divisor_low;

  modport source (
    output valid, action, dividend_high, dividend_low, divisor_high, divisor_low,
    input  ready
  );
  modport sink (
    input  valid, action, dividend_high, dividend_low, divisor_high, divisor_low,
    output ready
  );
endinterface

@@ src/div128_out_if.sv @@
// Result channel of the 128-bit divider: valid/ready plus result fields.
// Depends on nothing beyond the language itself.
interface div128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] quotient_high;
  logic [63:0] quotient_low;
  logic [63:0] remainder_high;
  logic [63:0] remainder_low;
  logic        divide_by_zero;

  modport source (
    output valid, quotient_high, quotient_low, remainder_high, remainder_low,
           divide_by_zero,
    input  ready
  );
  modport sink (
    input  valid, quotient_high, quotient_low, remainder_high, remainder_low,
           divide_by_zero,
    output ready
  );
endinterface

@@ src/div128_core.sv @@
// Sequencer and datapath of the restoring divider around one shared subtractor.
// Depends on div128_pkg and divide_128_bit_assert.svh.
`include "divide_128_bit_assert.svh"

module div128_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  div128_pkg::operand_t operand,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_take,
  output div128_pkg::result_t  result
);
  import div128_pkg::*;

  state_t state, state_next;
  word_t  rem;       // partial remainder
  word_t  nq;        // dividend bits shift out, quotient bits shift in
  word_t  dvs;       // divisor (magnitude after sign handling)
  count_t count;
  logic   signed_mode;
  logic   neg_n;
  logic   neg_d;
  logic   neg_q;
  logic   dz;

  // Shared 129-bit subtractor; the extra top bit of diff is the borrow.
  logic [DataWidth:0]   sub_a;
  logic [DataWidth:0]   sub_b;
  logic [DataWidth+1:0] diff;
  logic                 ge;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      ST_NEG_N: begin
        sub_b = {1'b0, nq};
      end
      ST_NEG_D: begin
        sub_b = {1'b0, dvs};
      end
      ST_DIV: begin
        sub_a = {rem, nq[DataWidth-1]};
        sub_b = {1'b0, dvs};
      end
      ST_NEG_Q: begin
        sub_b = {1'b0, nq};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[DataWidth+1];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = (operand.divisor == '0) ? ST_DONE : ST_NEG_N;
        end
      end
      ST_NEG_N: state_next = ST_NEG_D;
      ST_NEG_D: state_next = ST_DIV;
      ST_DIV: begin
        if (count == '0) begin
          state_next = ST_NEG_Q;
        end
      end
      ST_NEG_Q: state_next = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          dvs         <= operand.divisor;
          count       <= count_t'(DataWidth - 1);
          signed_mode <= (operand.action == ACT_SIGNED);
          neg_n       <= (operand.action == ACT_SIGNED) && operand.dividend[SignBit];
          neg_d       <= (operand.action == ACT_SIGNED) && operand.divisor[SignBit];
          neg_q       <= (operand.action == ACT_SIGNED) &&
                         (operand.dividend[SignBit] ^ operand.divisor[SignBit]);
          if (operand.divisor == '0) begin
            // Zero divisor: all-ones quotient, raw dividend as remainder.
            dz  <= 1'b1;
            nq  <= '1;
            rem <= operand.dividend;
          end else begin
            dz  <= 1'b0;
            nq  <= operand.dividend;
            rem <= '0;
          end
        end
      end
      ST_NEG_N: begin
        if (neg_n) begin
          nq <= diff[DataWidth-1:0];
        end
      end
      ST_NEG_D: begin
        if (neg_d) begin
          dvs <= diff[DataWidth-1:0];
        end
      end
      ST_DIV: begin
        rem   <= ge ? diff[DataWidth-1:0] : {rem[DataWidth-2:0], nq[DataWidth-1]};
        nq    <= {nq[DataWidth-2:0], ge};
        count <= count - count_t'(1);
      end
      ST_NEG_Q: begin
        if (neg_q) begin
          nq <= diff[DataWidth-1:0];
        end
        if (signed_mode) begin
          rem <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign idle                  = (state == ST_IDLE);
  assign res_valid             = (state == ST_DONE);
  assign result.quotient       = nq;
  assign result.remainder      = rem;
  assign result.divide_by_zero = dz;

  `DIV128_ASSERT_IMP(a_start_idle, start, state == ST_IDLE, "start while divider busy")
  `DIV128_ASSERT_NXT(a_count_step, state == ST_DIV && count != '0,
    state == ST_DIV && count == $past(count) - count_t'(1), "iteration count slipped")
  `DIV128_ASSERT_IMP(a_dz_quot, res_valid && dz, nq == '1,
    "zero divisor result lacks all-ones quotient")
  `DIV128_ASSERT_IMP(a_signed_rem, res_valid && signed_mode && !dz, rem == '0,
    "signed result carries nonzero remainder")

endmodule

@@ src/divide_128_bit.sv @@
// Top level of the 128-bit integer divider: handshake channels and result register.
// Depends on div128_pkg, div128_in_if, div128_out_if and div128_core.
//
// Usage: one operand word enters on the operands channel (valid/ready); a word
// is taken at a rising edge where both are high. It carries the mode bit
// (action: 0 unsigned with remainder, 1 signed quotient only) and the dividend
// and divisor as 64-bit halves. One result word leaves on the results channel.
// Sequence: an accepted word passes the dividend and divisor sign fix-up,
// 128 restoring steps and the quotient sign fix-up, then waits in the done
// state for hand-off to the result register. A zero divisor skips the loop
// and goes straight to the done state with divide_by_zero set, an all-ones
// quotient and the raw dividend as remainder. The single 129-bit subtractor
// is shared by all steps, so one word is in flight at a time.
// Stalls: a finished result waits in the output register while the core takes
// the next operand word; a second finished result holds in the core until the
// receiver drains the register. Nothing is dropped or repeated.
// Reset (rst, synchronous, active high) returns the sequencer to idle and
// empties the output register.

module divide_128_bit (
  input  logic            clk,
  input  logic            rst,
  div128_in_if.sink       operands,
  div128_out_if.source    results
);
  import div128_pkg::*;

  operand_t core_operand;
  result_t  core_result;
  result_t  out_data;
  logic     core_idle;
  logic     core_valid;
  logic     core_take;
  logic     out_valid;

  // Operands are accepted whenever the core is between items.
  assign operands.ready = core_idle;

  assign core_operand.action   = operands.action;
  assign core_operand.dividend = {operands.dividend_high, operands.dividend_low};
  assign core_operand.divisor  = {operands.divisor_high, operands.divisor_low};

  div128_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (operands.valid && operands.ready),
    .operand   (core_operand),
    .idle      (core_idle),
    .res_valid (core_valid),
    .res_take  (core_take),
    .result    (core_result)
  );

  // The output register is loaded when it is empty or being drained this cycle.
  assign core_take = core_valid && (!out_valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_take) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_take) begin
      out_data <= core_result;
    end
  end

  assign results.valid          = out_valid;
  assign results.quotient_high  = out_data.quotient[DataWidth-1:HalfWidth];
  assign results.quotient_low   = out_data.quotient[HalfWidth-1:0];
  assign results.remainder_high = out_data.remainder[DataWidth-1:HalfWidth];
  assign results.remainder_low  = out_data.remainder[HalfWidth-1:0];
  assign results.divide_by_zero = out_data.divide_by_zero;

endmodule
